// ===== rtl/core/hba_pkg.sv =====
package hba_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int CFG_W    = 9;
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int DIM_A    = (COLS_W > ROWS_W) ? COLS_W : ROWS_W;
  localparam int DIM_W    = (DIM_A > CFG_W) ? DIM_A : CFG_W;
  localparam int XY_W     = DIM_W + 1;

  localparam int COORD_W  = 8;
  localparam int RAD_W    = 6;
  localparam int OFS_W    = RAD_W + 1;
  localparam int R2_W     = 2 * RAD_W;
  localparam int D2_W     = 2 * RAD_W + 1;
  localparam int VAL_W    = 32;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_ROWS   = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(15);
  localparam logic [CFG_W-1:0] COLS_RST   = CFG_W'(100);
  localparam logic [CFG_W-1:0] ROWS_RST   = CFG_W'(100);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BUMP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } in_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             status;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_BUMP,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    GOP_NONE,
    GOP_RMW,
    GOP_ZERO,
    GOP_READ
  } grid_op_t;

  typedef struct packed {
    grid_op_t          op;
    logic [ADDR_W-1:0] addr;
    logic [R2_W-1:0]   add;
  } grid_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] x,
                                                 input logic [DIM_W-1:0] y);
    cell_addr = ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x);
  endfunction

endpackage

// ===== rtl/core/hba_grid.sv =====
module hba_grid (
  input  logic                     clk,
  input  logic                     rst,
  input  hba_pkg::grid_req_t       req,
  output logic [hba_pkg::VAL_W-1:0] rd_data
);

  logic [hba_pkg::VAL_W-1:0]  mem [hba_pkg::DEPTH];

  logic                        rmw_pend;
  logic [hba_pkg::ADDR_W-1:0]  rmw_addr;
  logic [hba_pkg::R2_W-1:0]    rmw_add;

  logic                        wr_en;
  logic [hba_pkg::ADDR_W-1:0]  wr_addr;
  logic [hba_pkg::VAL_W-1:0]   wr_data;
  logic [hba_pkg::VAL_W:0]     sum;

  always_comb begin
    sum = {1'b0, rd_data} + (hba_pkg::VAL_W + 1)'(rmw_add);
    wr_en   = 1'b0;
    wr_addr = req.addr;
    wr_data = '0;
    if (rmw_pend) begin
      wr_en   = 1'b1;
      wr_addr = rmw_addr;
      wr_data = sum[hba_pkg::VAL_W] ? '1 : sum[hba_pkg::VAL_W-1:0];
    end else if (req.op == hba_pkg::GOP_ZERO) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmw_pend <= 1'b0;
    end else begin
      rmw_pend <= (req.op == hba_pkg::GOP_RMW);
    end
    rmw_addr <= req.addr;
    rmw_add  <= req.add;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[req.addr];
  end

endmodule

// ===== rtl/core/heightmap_bump_accumulator_core.sv =====
// Height grid with paraboloid bump accumulation.
// Input channel (in_valid/in_stall/in_data) takes one command beat: clear the
// grid, add a bump centered at (col,row), or read one cell. Output channel
// (out_valid/out_stall/out_data) returns exactly one beat per command: the
// cell height for a read, zero otherwise, and status set when a bump or read
// lands outside the grid in use. Config writes (cfg_write/cfg_index/cfg_data)
// set radius, grid_cols and grid_rows; write them only while idle.
// One command is in work at a time; in_stall is high until it is finished.
// Steps per command, at most one read-modify-write per memory cycle:
//   bump:  offsets -radius..radius-1 on both axes, then ST_DRAIN
//   clear: all MAX_ROWS*MAX_COLS cells, one cell zeroed per cycle
//   read:  ST_READ, then ST_READ_WAIT; no-cell commands skip to ST_RESULT
// The result beat comes out in the same cycle as the next command can be taken.
// After reset the grid is zeroed by the same sweep, during which in_stall
// stays high; config writes are taken as usual.
// The result sits in an output register; while the receiver stalls it holds,
// and the next command is still accepted and worked on, waiting only for the
// register to free up before handing over its own result.
module heightmap_bump_accumulator_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hba_pkg::in_beat_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hba_pkg::out_beat_t    out_data,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [hba_pkg::CFG_W-1:0] cfg_data
);

  hba_pkg::state_t              state;
  hba_pkg::state_t              state_next;

  logic [hba_pkg::RAD_W-1:0]    radius;
  logic [hba_pkg::CFG_W-1:0]    grid_cols;
  logic [hba_pkg::CFG_W-1:0]    grid_rows;

  hba_pkg::in_beat_t            item;
  hba_pkg::out_beat_t           res;
  logic [hba_pkg::R2_W-1:0]     r2;
  logic signed [hba_pkg::OFS_W-1:0] di;
  logic signed [hba_pkg::OFS_W-1:0] dj;
  logic [hba_pkg::ADDR_W-1:0]   sweep;

  hba_pkg::grid_req_t           req;
  logic [hba_pkg::VAL_W-1:0]    rd_data;

  logic [hba_pkg::DIM_W-1:0]    ncols;
  logic [hba_pkg::DIM_W-1:0]    nrows;
  logic                         in_inside;
  logic                         accept;
  logic                         out_free;
  logic                         sweep_last;

  logic signed [hba_pkg::OFS_W-1:0] r_pos;
  logic signed [hba_pkg::OFS_W-1:0] r_neg;
  logic signed [hba_pkg::OFS_W-1:0] r_last;
  logic signed [hba_pkg::XY_W-1:0]  bx;
  logic signed [hba_pkg::XY_W-1:0]  by;
  logic signed [hba_pkg::D2_W-1:0]  di_e;
  logic signed [hba_pkg::D2_W-1:0]  dj_e;
  logic [hba_pkg::D2_W-1:0]     d2;
  logic                         hit;
  logic                         win_last;

  hba_grid u_grid (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  always_comb begin
    ncols = hba_pkg::DIM_W'(grid_cols);
    if (grid_cols == '0) begin
      ncols = hba_pkg::DIM_W'(1);
    end else if (hba_pkg::DIM_W'(grid_cols) > hba_pkg::DIM_W'(hba_pkg::MAX_COLS)) begin
      ncols = hba_pkg::DIM_W'(hba_pkg::MAX_COLS);
    end
    nrows = hba_pkg::DIM_W'(grid_rows);
    if (grid_rows == '0) begin
      nrows = hba_pkg::DIM_W'(1);
    end else if (hba_pkg::DIM_W'(grid_rows) > hba_pkg::DIM_W'(hba_pkg::MAX_ROWS)) begin
      nrows = hba_pkg::DIM_W'(hba_pkg::MAX_ROWS);
    end
  end

  assign in_inside = (hba_pkg::DIM_W'(in_data.col) < ncols) &&
                     (hba_pkg::DIM_W'(in_data.row) < nrows);
  assign in_stall   = (state != hba_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign sweep_last = (sweep == hba_pkg::ADDR_W'(hba_pkg::DEPTH - 1));

  // bump window walk: di over columns, dj over rows
  always_comb begin
    r_pos  = signed'({1'b0, radius});
    r_neg  = -r_pos;
    r_last = r_pos - hba_pkg::OFS_W'(1);
    bx = signed'(hba_pkg::XY_W'(item.col)) + hba_pkg::XY_W'(di);
    by = signed'(hba_pkg::XY_W'(item.row)) + hba_pkg::XY_W'(dj);
    di_e = hba_pkg::D2_W'(di);
    dj_e = hba_pkg::D2_W'(dj);
    d2 = unsigned'(di_e * di_e) + unsigned'(dj_e * dj_e);
    hit = (bx >= 0) && (bx < signed'({1'b0, ncols})) &&
          (by >= 0) && (by < signed'({1'b0, nrows})) &&
          (d2 <= hba_pkg::D2_W'(r2));
    win_last = (di == r_last) && (dj == r_last);
  end

  always_comb begin
    state_next = state;
    req.op   = hba_pkg::GOP_NONE;
    req.addr = sweep;
    req.add  = '0;
    unique case (state)
      hba_pkg::ST_INIT: begin
        req.op = hba_pkg::GOP_ZERO;
        if (sweep_last) begin
          state_next = hba_pkg::ST_IDLE;
        end
      end
      hba_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            hba_pkg::CMD_CLEAR: state_next = hba_pkg::ST_CLEAR;
            hba_pkg::CMD_BUMP: begin
              state_next = (in_inside && radius != '0) ? hba_pkg::ST_BUMP
                                                       : hba_pkg::ST_RESULT;
            end
            hba_pkg::CMD_READ: begin
              state_next = in_inside ? hba_pkg::ST_READ : hba_pkg::ST_RESULT;
            end
            default: state_next = hba_pkg::ST_RESULT;
          endcase
        end
      end
      hba_pkg::ST_CLEAR: begin
        req.op = hba_pkg::GOP_ZERO;
        if (sweep_last) begin
          state_next = hba_pkg::ST_RESULT;
        end
      end
      hba_pkg::ST_BUMP: begin
        req.op   = hit ? hba_pkg::GOP_RMW : hba_pkg::GOP_NONE;
        req.addr = hba_pkg::cell_addr(bx[hba_pkg::DIM_W-1:0], by[hba_pkg::DIM_W-1:0]);
        req.add  = r2 - d2[hba_pkg::R2_W-1:0];
        if (win_last) begin
          state_next = hba_pkg::ST_DRAIN;
        end
      end
      hba_pkg::ST_DRAIN: state_next = hba_pkg::ST_RESULT;
      hba_pkg::ST_READ: begin
        req.op   = hba_pkg::GOP_READ;
        req.addr = hba_pkg::cell_addr(hba_pkg::DIM_W'(item.col), hba_pkg::DIM_W'(item.row));
        state_next = hba_pkg::ST_READ_WAIT;
      end
      hba_pkg::ST_READ_WAIT: state_next = hba_pkg::ST_RESULT;
      hba_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = hba_pkg::ST_IDLE;
        end
      end
      default: state_next = hba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hba_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= hba_pkg::RADIUS_RST;
      grid_cols <= hba_pkg::COLS_RST;
      grid_rows <= hba_pkg::ROWS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hba_pkg::REG_RADIUS: radius    <= cfg_data[hba_pkg::RAD_W-1:0];
        hba_pkg::REG_COLS:   grid_cols <= cfg_data;
        hba_pkg::REG_ROWS:   grid_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (state == hba_pkg::ST_INIT || state == hba_pkg::ST_CLEAR) begin
      sweep <= sweep_last ? '0 : sweep + hba_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item       <= in_data;
      res.value  <= '0;
      res.status <= !in_inside && (in_data.command == hba_pkg::CMD_BUMP ||
                                   in_data.command == hba_pkg::CMD_READ);
      r2         <= hba_pkg::R2_W'(radius) * hba_pkg::R2_W'(radius);
      di         <= r_neg;
      dj         <= r_neg;
    end else if (state == hba_pkg::ST_BUMP) begin
      if (dj == r_last) begin
        dj <= r_neg;
        di <= di + hba_pkg::OFS_W'(1);
      end else begin
        dj <= dj + hba_pkg::OFS_W'(1);
      end
    end else if (state == hba_pkg::ST_READ_WAIT) begin
      res.value <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hba_pkg::ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hba_pkg::ST_RESULT && out_free) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/core/hba_checker.sv =====
module hba_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hba_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one command at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // reset starts the zeroing sweep with nothing pending
  assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("block not held off after reset");

  // an out-of-grid result carries no height
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.value == '0)
    else $error("error status with nonzero value");

endmodule

bind heightmap_bump_accumulator_core hba_checker u_hba_checker (.*);
